### sv/vzbm_pkg.sv
// ----------------------------------------------------------------------------
// vzbm_pkg
// Shared constants, types and command/status bundles for the viewed-zone
// bitmap marker.
// ----------------------------------------------------------------------------
package vzbm_pkg;

    localparam int ZONE_SHIFT = 6;
    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int ROW_AW     = $clog2(GRID_ROWS);
    localparam int ZONE_W     = 7;   // holds 0..64
    localparam int MAG_W      = 24;  // |v| * 100 fits here
    localparam int QUO_W      = 26;  // signed quotient
    localparam int ZOOM_W     = 11;
    localparam int STEP_W     = $clog2(MAG_W);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_XEIG   = 3'd2,
        CFG_YEIG   = 3'd3,
        CFG_ZOOM   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [12:0]       width_px;
        logic [12:0]       height_px;
        logic [1:0]        x_eig;
        logic [1:0]        y_eig;
        logic [ZOOM_W-1:0] zoom;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       clear;
        logic       prep;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic [1:0] idx;
        logic       bound;
        logic       row_rd;
        logic       row_wr;
        logic       rd_issue;
        logic       rd_capture;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic nonempty;
        logic row_last;
    } t_dp_sts;

endpackage

### sv/vzbm_if.sv
// ----------------------------------------------------------------------------
// vzbm channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface vzbm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] scroll_x;
    logic signed [15:0] scroll_y;
    logic signed [15:0] box_left;
    logic signed [15:0] box_bottom;
    logic signed [15:0] box_right;
    logic signed [15:0] box_top;
    logic [5:0]         row_select;

    modport source (output valid, cmd, scroll_x, scroll_y, box_left, box_bottom,
                    box_right, box_top, row_select, input ready);
    modport sink   (input valid, cmd, scroll_x, scroll_y, box_left, box_bottom,
                    box_right, box_top, row_select, output ready);
endinterface

interface vzbm_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  zone_left;
    logic [6:0]  zone_bottom;
    logic [6:0]  zone_right;
    logic [6:0]  zone_top;
    logic [63:0] row_bits;

    modport source (output valid, zone_left, zone_bottom, zone_right, zone_top,
                    row_bits, input ready);
    modport sink   (input valid, zone_left, zone_bottom, zone_right, zone_top,
                    row_bits, output ready);
endinterface

### sv/vzbm_ram.sv
// ----------------------------------------------------------------------------
// vzbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vzbm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/vzbm_ctrl.sv
// ----------------------------------------------------------------------------
// vzbm_ctrl
// Sequencer: command decode, divider step count, row walk, result hand-off.
// ----------------------------------------------------------------------------
module vzbm_ctrl import vzbm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic [1:0] i_cmd,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_PREP   = 11'b000_0000_0010,
        S_DLOAD  = 11'b000_0000_0100,
        S_DSTEP  = 11'b000_0000_1000,
        S_DSTORE = 11'b000_0001_0000,
        S_BOUND  = 11'b000_0010_0000,
        S_ROWRD  = 11'b000_0100_0000,
        S_ROWWR  = 11'b000_1000_0000,
        S_RDREQ  = 11'b001_0000_0000,
        S_RDCAP  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_idx, n_idx;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (t_cmd_code'(i_cmd))
                        CMD_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_OUT;
                        end
                        CMD_MARK: n_state = S_PREP;
                        CMD_READ: n_state = S_RDREQ;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_idx      = 2'd0;
                n_state    = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(MAG_W - 1)) begin
                    n_state = S_DSTORE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DSTORE: begin
                o_cmd.div_store = 1'b1;
                if (r_idx == 2'd3) begin
                    n_state = S_BOUND;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DLOAD;
                end
            end
            S_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state     = S_ROWRD;
            end
            S_ROWRD: begin
                if (i_sts.nonempty) begin
                    o_cmd.row_rd = 1'b1;
                    n_state      = S_ROWWR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ROWWR: begin
                o_cmd.row_wr = 1'b1;
                n_state      = i_sts.row_last ? S_OUT : S_ROWRD;
            end
            S_RDREQ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RDCAP;
            end
            S_RDCAP: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
        end
    end
endmodule

### sv/vzbm_dp.sv
// ----------------------------------------------------------------------------
// vzbm_dp
// Datapath: rectangle prep, shared zoom divider, zone bounds, map RMW,
// result register.
// ----------------------------------------------------------------------------
module vzbm_dp import vzbm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    vzbm_in_if.sink    i_in,
    vzbm_out_if.source o_out
);
    // |v| * 100, v is 18-bit signed
    function automatic logic [MAG_W-1:0] scale100(input logic signed [17:0] v);
        logic [17:0] mag;
        mag = v[17] ? 18'(-v) : 18'(v);
        return MAG_W'({6'd0, mag} * 24'd100);
    endfunction

    function automatic logic [ZONE_W-1:0] zone_cnt(input logic [12:0] px, input int cap);
        logic [13:0] n;
        n = 14'({1'b0, px} + 14'((1 << ZONE_SHIFT) - 1)) >> ZONE_SHIFT;
        return (n > 14'(cap)) ? ZONE_W'(cap) : ZONE_W'(n);
    endfunction

    // captured item
    logic signed [15:0] r_sx, r_sy, r_bl, r_bb, r_br, r_bt;
    logic [ROW_AW-1:0]  r_row_sel;

    logic [MAG_W-1:0]        r_mag [4];
    logic                    r_neg [4];
    logic signed [QUO_W-1:0] r_v   [4];
    logic [ZOOM_W-1:0]       r_rem;
    logic [MAG_W-1:0]        r_quo;

    logic [ZONE_W-1:0] r_zx0, r_zx1, r_zy0, r_zy1, r_rows, r_y;
    logic              r_nonempty;
    logic [63:0]       r_mask, r_row_bits;
    logic [GRID_ROWS-1:0] r_vld;

    logic        r_out_valid;
    logic [6:0]  r_o_zl, r_o_zb, r_o_zr, r_o_zt;
    logic [63:0] r_o_bits;

    // rectangle corners, 18-bit signed
    logic signed [17:0] w_x0, w_y0, w_x1, w_y1;
    assign w_x0 = 18'(r_sx);
    assign w_y1 = 18'(r_sy);
    assign w_x1 = 18'(r_sx) + (18'(r_br) - 18'(r_bl));
    assign w_y0 = 18'(r_sy) - (18'(r_bt) - 18'(r_bb));

    // divider
    logic [ZOOM_W-1:0] w_zoom;
    logic [ZOOM_W:0]   w_trial;
    logic              w_ge;
    assign w_zoom  = (i_cfg.zoom == '0) ? ZOOM_W'(1) : i_cfg.zoom;
    assign w_trial = {r_rem, r_quo[MAG_W-1]};
    assign w_ge    = w_trial >= {1'b0, w_zoom};

    // zone bounds
    logic [ZONE_W-1:0] w_cols, w_rows;
    logic signed [QUO_W-1:0] w_zx0, w_zy0, w_zx1, w_zy1;
    logic signed [QUO_W-1:0] w_cx0, w_cy0, w_cx1, w_cy1, w_scols, w_srows;
    logic [ZONE_W-1:0] w_sx0, w_sy0, w_sx1, w_sy1;
    logic [63:0]       w_upper, w_lower;

    always_comb begin
        w_cols  = zone_cnt(i_cfg.width_px, GRID_COLS);
        w_rows  = zone_cnt(i_cfg.height_px, GRID_ROWS);
        w_scols = QUO_W'(w_cols);
        w_srows = QUO_W'(w_rows);
        w_zx0 = (r_v[0] >>> i_cfg.x_eig) >>> ZONE_SHIFT;
        w_zy0 = (r_v[1] >>> i_cfg.y_eig) >>> ZONE_SHIFT;
        w_zx1 = ((r_v[2] >>> i_cfg.x_eig) + QUO_W'((1 << ZONE_SHIFT) - 1)) >>> ZONE_SHIFT;
        w_zy1 = ((r_v[3] >>> i_cfg.y_eig) + QUO_W'((1 << ZONE_SHIFT) - 1)) >>> ZONE_SHIFT;
        w_cx0 = (w_zx0 < 0) ? '0 : w_zx0;
        w_cy0 = (w_zy0 < 0) ? '0 : w_zy0;
        w_cx1 = (w_zx1 > w_scols) ? w_scols : w_zx1;
        w_cy1 = (w_zy1 > w_srows) ? w_srows : w_zy1;
        w_sx0 = (w_cx0 > w_scols) ? w_cols : w_cx0[ZONE_W-1:0];
        w_sy0 = (w_cy0 > w_srows) ? w_rows : w_cy0[ZONE_W-1:0];
        w_sx1 = (w_cx1 < 0) ? '0 : w_cx1[ZONE_W-1:0];
        w_sy1 = (w_cy1 < 0) ? '0 : w_cy1[ZONE_W-1:0];
        w_upper = (w_sx1 >= ZONE_W'(64)) ? '1 : ((64'd1 << w_sx1) - 64'd1);
        w_lower = (64'd1 << w_sx0) - 64'd1;
    end

    // map access; zone row y sits in stored row rows-1-y
    logic [ZONE_W-1:0] w_row_full;
    logic [ROW_AW-1:0] w_row_addr, w_raddr;
    logic [63:0]       w_rdata, w_old;
    assign w_row_full = r_rows - ZONE_W'(1) - r_y;
    assign w_row_addr = w_row_full[ROW_AW-1:0];
    assign w_raddr    = i_cmd.row_rd ? w_row_addr : r_row_sel;
    assign w_old      = r_vld[w_row_addr] ? w_rdata : '0;

    vzbm_ram #(.WIDTH(64), .DEPTH(GRID_ROWS)) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.row_wr),
        .i_waddr (w_row_addr),
        .i_wdata (w_old | r_mask),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sx       <= i_in.scroll_x;
            r_sy       <= i_in.scroll_y;
            r_bl       <= i_in.box_left;
            r_bb       <= i_in.box_bottom;
            r_br       <= i_in.box_right;
            r_bt       <= i_in.box_top;
            r_row_sel  <= i_in.row_select;
            r_zx0      <= '0;
            r_zy0      <= '0;
            r_zx1      <= '0;
            r_zy1      <= '0;
            r_row_bits <= '0;
        end
        if (i_cmd.prep) begin
            r_mag[0] <= scale100(w_x0);
            r_mag[1] <= scale100(w_y0);
            r_mag[2] <= scale100(w_x1);
            r_mag[3] <= scale100(w_y1);
            r_neg[0] <= w_x0[17];
            r_neg[1] <= w_y0[17];
            r_neg[2] <= w_x1[17];
            r_neg[3] <= w_y1[17];
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= r_mag[i_cmd.idx];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? ZOOM_W'(w_trial - {1'b0, w_zoom}) : w_trial[ZOOM_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], w_ge};
        end
        if (i_cmd.div_store) begin
            r_v[i_cmd.idx] <= r_neg[i_cmd.idx] ? -QUO_W'(r_quo) : QUO_W'(r_quo);
        end
        if (i_cmd.bound) begin
            r_zx0      <= w_sx0;
            r_zy0      <= w_sy0;
            r_zx1      <= w_sx1;
            r_zy1      <= w_sy1;
            r_rows     <= w_rows;
            r_y        <= w_sy0;
            r_mask     <= w_upper & ~w_lower;
            r_nonempty <= (w_cx0 < w_cx1) && (w_cy0 < w_cy1);
        end
        if (i_cmd.row_wr) begin
            r_y <= r_y + ZONE_W'(1);
        end
        if (i_cmd.rd_capture) begin
            r_row_bits <= r_vld[r_row_sel] ? w_rdata : '0;
        end
        if (i_cmd.load_out) begin
            r_o_zl   <= r_zx0;
            r_o_zb   <= r_zy0;
            r_o_zr   <= r_zx1;
            r_o_zt   <= r_zy1;
            r_o_bits <= r_row_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_vld <= '0;
            end else if (i_cmd.row_wr) begin
                r_vld[w_row_addr] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || o_out.ready;
    assign o_sts.nonempty = r_nonempty;
    assign o_sts.row_last = (r_y + ZONE_W'(1)) == r_zy1;

    assign o_out.valid       = r_out_valid;
    assign o_out.zone_left   = r_o_zl;
    assign o_out.zone_bottom = r_o_zb;
    assign o_out.zone_right  = r_o_zr;
    assign o_out.zone_top    = r_o_zt;
    assign o_out.row_bits    = r_o_bits;
endmodule

### sv/viewed_zone_bitmap_marker.sv
// Mark: the zoom divider runs one quotient bit a cycle, 24 bits for each of the
//   four corners, then each marked zone row (up to 64) is read and written back;
//   clear and unused commands go straight to the output, a row read via the map.
// Throughput: one item at a time; a finished result waits in the output
//   register while the next item is taken.
// Reset (synchronous, active low): map reads as all zeros, config as 4096,
//   4096, 1, 1, 100; no clearing pass is needed.
// ----------------------------------------------------------------------------
// viewed_zone_bitmap_marker
// Records which 64x64-pixel zones of an image have been shown. Clear, mark
// a redraw rectangle, or read back one stored row of the zone map.
// ----------------------------------------------------------------------------
module viewed_zone_bitmap_marker import vzbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_wdata,
    vzbm_in_if.sink     i_in,
    vzbm_out_if.source  o_out
);
    // configuration registers; the user must write them only while idle (not enforced)
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_px  <= 13'd4096;
            r_cfg.height_px <= 13'd4096;
            r_cfg.x_eig     <= 2'd1;
            r_cfg.y_eig     <= 2'd1;
            r_cfg.zoom      <= ZOOM_W'(100);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_cfg.width_px  <= i_cfg_wdata;
                CFG_HEIGHT: r_cfg.height_px <= i_cfg_wdata;
                CFG_XEIG:   r_cfg.x_eig     <= i_cfg_wdata[1:0];
                CFG_YEIG:   r_cfg.y_eig     <= i_cfg_wdata[1:0];
                CFG_ZOOM:   r_cfg.zoom      <= i_cfg_wdata[ZOOM_W-1:0];
                default: ;  // writes beyond the list are dropped
            endcase
        end
    end

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // the controller takes a transfer only from its idle state
    assign i_in.ready = w_in_ready;

    vzbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_cmd      (i_in.cmd),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    vzbm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

### tb/viewed_zone_bitmap_marker_tb.sv
// ----------------------------------------------------------------------------
// viewed_zone_bitmap_marker_tb
// Self-checking bench for the viewed-zone bitmap marker. It drives clear,
// mark, read and unused commands under random idling on both channels. A
// model of the zone map predicts every result, and each result is checked
// field by field. Several register settings are tried, the extremes among
// them, and each is written while the block is idle.
// ----------------------------------------------------------------------------
module viewed_zone_bitmap_marker_tb;
    import vzbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] sx, sy, bl, bb, br, bt;
        logic [5:0]         row;
    } t_cmd_item;

    typedef struct {
        logic [6:0]  zl, zb, zr, zt;
        logic [63:0] bits;
    } t_zone_result;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [12:0] i_cfg_wdata;

    vzbm_in_if  cmd_ch ();
    vzbm_out_if res_ch ();

    viewed_zone_bitmap_marker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (cmd_ch.sink),
        .o_out       (res_ch.source)
    );

    // Model state: zone map plus shadow copy of the registers
    logic [63:0] viewed_map [GRID_ROWS];
    logic [12:0] m_width, m_height;
    logic [1:0]  m_xeig, m_yeig;
    logic [10:0] m_zoom;

    t_cmd_item    pending_cmds [$];
    t_zone_result zone_results [$];

    int  mismatches;
    bit  idle_off;   // stretch with no idling on either side
    int  quiet_cycles;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint rescale_zoom(longint v, longint zoom);
        if (zoom == 100) return v;
        return (v * 100) / zoom;   // truncates toward zero
    endfunction

    function automatic longint zones_of(logic [12:0] px, longint cap);
        longint n;
        n = (longint'(px) + (1 << ZONE_SHIFT) - 1) >>> ZONE_SHIFT;
        return (n > cap) ? cap : n;
    endfunction

    function automatic longint clip(longint v, longint hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_zone_result predict_zone_result(t_cmd_item it);
        t_zone_result res;
        longint zoom, cols, rows, x0, x1, y0, y1, r;
        logic [63:0] upper, lower, mask;
        res = '{default: '0};
        case (t_cmd_code'(it.cmd))
            CMD_CLEAR: begin
                foreach (viewed_map[i]) viewed_map[i] = '0;
            end
            CMD_MARK: begin
                zoom = (m_zoom == 0) ? 1 : longint'(m_zoom);
                cols = zones_of(m_width, GRID_COLS);
                rows = zones_of(m_height, GRID_ROWS);
                x0 = longint'(it.sx);
                x1 = longint'(it.sx) + (longint'(it.br) - longint'(it.bl));
                y0 = longint'(it.sy) - (longint'(it.bt) - longint'(it.bb));
                y1 = longint'(it.sy);
                // arithmetic shift of a signed longint floors
                x0 = rescale_zoom(x0, zoom) >>> m_xeig;
                x1 = rescale_zoom(x1, zoom) >>> m_xeig;
                y0 = rescale_zoom(y0, zoom) >>> m_yeig;
                y1 = rescale_zoom(y1, zoom) >>> m_yeig;
                x0 = x0 >>> ZONE_SHIFT;
                y0 = y0 >>> ZONE_SHIFT;
                x1 = (x1 + (1 << ZONE_SHIFT) - 1) >>> ZONE_SHIFT;
                y1 = (y1 + (1 << ZONE_SHIFT) - 1) >>> ZONE_SHIFT;
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > cols) x1 = cols;
                if (y1 > rows) y1 = rows;
                if (x0 < x1 && y0 < y1) begin
                    upper = (x1 >= 64) ? '1 : ((64'd1 << x1) - 64'd1);
                    lower = (64'd1 << x0) - 64'd1;
                    mask  = upper & ~lower;
                    for (longint y = y0; y < y1; y++) begin
                        r = rows - 1 - y;   // rows stored with Y inverted
                        if (r >= 0 && r < GRID_ROWS) viewed_map[r] |= mask;
                    end
                end
                res.zl = 7'(clip(x0, cols));
                res.zb = 7'(clip(y0, rows));
                res.zr = 7'(clip(x1, cols));
                res.zt = 7'(clip(y1, rows));
            end
            CMD_READ: begin
                if (it.row < GRID_ROWS) res.bits = viewed_map[it.row];
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes items off the pending queue, predicts on each transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd_item it;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                it.cmd = cmd_ch.cmd;
                it.sx  = cmd_ch.scroll_x;
                it.sy  = cmd_ch.scroll_y;
                it.bl  = cmd_ch.box_left;
                it.bb  = cmd_ch.box_bottom;
                it.br  = cmd_ch.box_right;
                it.bt  = cmd_ch.box_top;
                it.row = cmd_ch.row_select;
                zone_results.push_back(predict_zone_result(it));
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_cmds.size() > 0 && (idle_off || $urandom_range(99) >= 34)) begin
                    it = pending_cmds.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.cmd        <= it.cmd;
                    cmd_ch.scroll_x   <= it.sx;
                    cmd_ch.scroll_y   <= it.sy;
                    cmd_ch.box_left   <= it.bl;
                    cmd_ch.box_bottom <= it.bb;
                    cmd_ch.box_right  <= it.br;
                    cmd_ch.box_top    <= it.bt;
                    cmd_ch.row_select <= it.row;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_zone_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (zone_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer");
                end else begin
                    want = zone_results.pop_front();
                    if (res_ch.zone_left !== want.zl || res_ch.zone_bottom !== want.zb ||
                        res_ch.zone_right !== want.zr || res_ch.zone_top !== want.zt ||
                        res_ch.row_bits !== want.bits) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result: exp l%0d b%0d r%0d t%0d bits %h, ",
                                      "got l%0d b%0d r%0d t%0d bits %h"},
                                     want.zl, want.zb, want.zr, want.zt, want.bits,
                                     res_ch.zone_left, res_ch.zone_bottom, res_ch.zone_right,
                                     res_ch.zone_top, res_ch.row_bits);
                    end
                end
            end
            res_ch.ready <= idle_off || ($urandom_range(99) >= 34);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transfer on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("viewed_zone_bitmap_marker: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_cmd_item cmd_item(logic [1:0] c, int sx, int sy, int bl, int bb,
                                           int br, int bt, int row);
        t_cmd_item it;
        it.cmd = c;
        it.sx = 16'(sx); it.sy = 16'(sy);
        it.bl = 16'(bl); it.bb = 16'(bb); it.br = 16'(br); it.bt = 16'(bt);
        it.row = 6'(row);
        return it;
    endfunction

    // Clear, unused, read and mark items; most marks land on the grid, some fully random
    function automatic t_cmd_item random_item();
        t_cmd_item it;
        int pick, w, h;
        it.cmd = CMD_MARK;
        it.sx = 16'($urandom); it.sy = 16'($urandom);
        it.bl = 16'($urandom); it.bb = 16'($urandom);
        it.br = 16'($urandom); it.bt = 16'($urandom);
        it.row = 6'($urandom);
        pick = $urandom_range(99);
        if (pick < 4)       it.cmd = CMD_CLEAR;
        else if (pick < 8)  it.cmd = CMD_NONE;
        else if (pick < 40) it.cmd = CMD_READ;
        else if (pick < 88) begin
            // well-formed redraw: box right/top at or beyond left/bottom
            w = $urandom_range(3000);
            h = $urandom_range(3000);
            it.sx = 16'(int'($urandom_range(10000)) - 1500);
            it.sy = 16'(int'($urandom_range(10000)) - 1000);
            it.bl = 16'(int'($urandom_range(4000)) - 2000);
            it.bb = 16'(int'($urandom_range(4000)) - 2000);
            it.br = 16'(int'(it.bl) + w);
            it.bt = 16'(int'(it.bb) + h);
        end
        return it;
    endfunction

    // sampled on the falling edge so that the driver's updates have settled
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || cmd_ch.valid || zone_results.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [12:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_WIDTH:  m_width  = val;
            CFG_HEIGHT: m_height = val;
            CFG_XEIG:   m_xeig   = val[1:0];
            CFG_YEIG:   m_yeig   = val[1:0];
            CFG_ZOOM:   m_zoom   = val[10:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int w, int h, int xe, int ye, int z);
        write_reg(CFG_WIDTH, 13'(w));
        write_reg(CFG_HEIGHT, 13'(h));
        write_reg(CFG_XEIG, 13'(xe));
        write_reg(CFG_YEIG, 13'(ye));
        write_reg(CFG_ZOOM, 13'(z));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int cfgs [7][5];
        cfgs = '{'{4096, 4096, 1, 1, 100}, '{1, 1, 0, 0, 1}, '{8191, 8191, 3, 3, 2047},
                 '{0, 0, 2, 1, 50}, '{700, 300, 2, 0, 37}, '{4096, 2000, 1, 3, 0},
                 '{1500, 4096, 0, 2, 1600}};
        mismatches = 0;
        idle_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        cmd_ch.valid = 1'b0; cmd_ch.cmd = '0;
        cmd_ch.scroll_x = '0; cmd_ch.scroll_y = '0;
        cmd_ch.box_left = '0; cmd_ch.box_bottom = '0;
        cmd_ch.box_right = '0; cmd_ch.box_top = '0; cmd_ch.row_select = '0;
        res_ch.ready = 1'b0;
        foreach (viewed_map[i]) viewed_map[i] = '0;
        m_width = 13'd4096; m_height = 13'd4096; m_xeig = 2'd1; m_yeig = 2'd1;
        m_zoom = 11'd100;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings
        pending_cmds.push_back(cmd_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(cmd_item(CMD_MARK, 0, 8191, 0, 0, 8191, 8191, 0));   // whole grid
        pending_cmds.push_back(cmd_item(CMD_READ, 0, 0, 0, 0, 0, 0, 63));
        pending_cmds.push_back(cmd_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(cmd_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        // empty rectangle: zero width and inverted box
        pending_cmds.push_back(cmd_item(CMD_MARK, 300, 300, 50, 0, 50, 200, 0));
        pending_cmds.push_back(cmd_item(CMD_MARK, 300, 300, 500, 0, 100, 200, 0));
        // extremes of the signed fields
        pending_cmds.push_back(cmd_item(CMD_MARK, -32768, -32768, 32767, 32767,
                                        -32768, -32768, 0));
        pending_cmds.push_back(cmd_item(CMD_MARK, 32767, 32767, -32768, -32768,
                                        32767, 32767, 0));
        pending_cmds.push_back(cmd_item(CMD_MARK, -32768, 32767, -32768, -32768,
                                        32767, 32767, 0));
        pending_cmds.push_back(cmd_item(CMD_MARK, 100, 1000, 0, 0, 129, 257, 0));
        pending_cmds.push_back(cmd_item(CMD_MARK, -200, 50, 0, 0, 300, 400, 0));
        pending_cmds.push_back(cmd_item(CMD_NONE, -1, -1, -1, -1, -1, -1, 63));
        for (int r = 0; r < 64; r += 9)
            pending_cmds.push_back(cmd_item(CMD_READ, 0, 0, 0, 0, 0, 0, r));
        pending_cmds.push_back(cmd_item(CMD_READ, 0, 0, 0, 0, 0, 0, 63));
        wait_idle();

        // Random phases over several settings; map kept across height change
        foreach (cfgs[p]) begin
            set_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4]);
            idle_off = (p == 4);
            for (int n = 0; n < 125; n++) pending_cmds.push_back(random_item());
            for (int r = 0; r < 64; r += 7)
                pending_cmds.push_back(cmd_item(CMD_READ, 0, 0, 0, 0, 0, 0, r));
            // sender holds until every result has arrived before the next phase
            wait_idle();
        end
        idle_off = 1'b0;

        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && zone_results.size() == 0)
            $display("viewed_zone_bitmap_marker: match");
        else
            $display("viewed_zone_bitmap_marker: mismatch");
        $finish;
    end

endmodule
